@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the timed drive command controller.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/core/tdc_pkg.sv @@
// Package for the timed drive command controller: command and register codes,
// output slot indexes, reset values and the servo step request struct. No dependencies.
package tdc_pkg;

  // Command codes carried in command_code
  typedef enum logic [7:0] {
    CMD_FWD        = 8'd0,
    CMD_BACK       = 8'd1,
    CMD_LEFT       = 8'd2,
    CMD_RIGHT      = 8'd3,
    CMD_FIRE       = 8'd4,
    CMD_PAN_RIGHT  = 8'd5,
    CMD_PAN_LEFT   = 8'd6,
    CMD_TILT_DOWN  = 8'd7,
    CMD_TILT_UP    = 8'd8
  } tdc_cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_MIN  = 2'd0,
    CFG_PAN_MAX  = 2'd1,
    CFG_TILT_MIN = 2'd2,
    CFG_TILT_MAX = 2'd3
  } tdc_cfg_t;

  localparam int TIME_W   = 32;
  localparam int SERVO_W  = 16;
  localparam int CODE_W   = 8;

  // Expiry slots, one per timed output
  localparam int SLOT_RF    = 0;
  localparam int SLOT_RB    = 1;
  localparam int SLOT_LF    = 2;
  localparam int SLOT_LB    = 3;
  localparam int SLOT_LASER = 4;
  localparam int SLOT_COUNT = 5;

  // Reset values
  localparam logic [SERVO_W-1:0] PAN_MIN_RST  = 16'd500;
  localparam logic [SERVO_W-1:0] PAN_MAX_RST  = 16'd2500;
  localparam logic [SERVO_W-1:0] TILT_MIN_RST = 16'd500;
  localparam logic [SERVO_W-1:0] TILT_MAX_RST = 16'd2500;
  localparam logic [SERVO_W-1:0] PAN_POS_RST  = 16'd1500;
  localparam logic [SERVO_W-1:0] TILT_POS_RST = 16'd500;

  // Servo move request: inc toward the maximum, dec toward the minimum
  typedef struct packed {
    logic inc;
    logic dec;
  } tdc_step_req_t;

endpackage

@@ rtl/core/timed_drive_command_controller.sv @@
// Timed drive command controller: wheel and laser expiry timers, pan/tilt
// servo periods with configurable limits. Depends on tdc_pkg, tdc_drive,
// tdc_servo_step and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one item per transfer carrying now_ms
//    and, when operation is 1, a command_code with an amount.
//  - Output channel (out_valid / out_stall): one result per item, five output
//    levels plus the current pan and tilt periods.
//  - Config port (cfg_write, cfg_index, cfg_data): writes pan/tilt limits;
//    write only while no item is in flight.
//  - Path: an item taken in sits in the input register, then its result is
//    loaded into the output register, from which it can transfer.
//  - Throughput: one item per cycle unless stalled; input and result registers form
//    a two-stage pipe, and state commits as an item enters the result register.
//  - Receiver stall: the result holds; the next item waits in the input register
//    and in_stall rises only once both registers are full.
//  - Reset: expiries clear to zero, pan 1500, tilt 500, limits 500/2500, both
//    registers empty.
`include "assert_macros.svh"

module timed_drive_command_controller
  import tdc_pkg::*;
#(
  parameter int AMOUNT_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SERVO_W-1:0]    cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [CODE_W-1:0]     command_code,
  input  logic [TIME_W-1:0]     amount,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  right_fwd_on,
  output logic                  right_back_on,
  output logic                  left_fwd_on,
  output logic                  left_back_on,
  output logic                  laser_on,
  output logic [SERVO_W-1:0]    pan_period,
  output logic [SERVO_W-1:0]    tilt_period
);

  localparam int AMT_W = 8 * AMOUNT_BYTES;
  localparam logic [TIME_W-1:0] AMT_MASK = TIME_W'((64'd1 << AMT_W) - 64'd1);

  // Limit registers
  logic [SERVO_W-1:0] pan_min, pan_max, tilt_min, tilt_max;

  // Input register
  logic                s1_valid;
  logic                s1_op;
  logic [TIME_W-1:0]   s1_now;
  logic [CODE_W-1:0]   s1_code;
  logic [TIME_W-1:0]   s1_amt;

  // Servo state
  logic [SERVO_W-1:0]  pan_pos, tilt_pos;
  logic [SERVO_W-1:0]  pan_next, tilt_next;
  tdc_step_req_t       pan_req, tilt_req;

  logic                  res_take;
  logic                  advance;
  logic                  in_xfer;
  logic [SLOT_COUNT-1:0] lvl;

  // Pipe control
  assign res_take = !out_valid || !out_stall;
  assign advance  = s1_valid && res_take;
  assign in_stall = s1_valid && !res_take;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_min  <= PAN_MIN_RST;
      pan_max  <= PAN_MAX_RST;
      tilt_min <= TILT_MIN_RST;
      tilt_max <= TILT_MAX_RST;
    end else if (cfg_write) begin
      unique case (tdc_cfg_t'(cfg_index))
        CFG_PAN_MIN:  pan_min  <= cfg_data;
        CFG_PAN_MAX:  pan_max  <= cfg_data;
        CFG_TILT_MIN: tilt_min <= cfg_data;
        CFG_TILT_MAX: tilt_max <= cfg_data;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op   <= operation;
      s1_now  <= now_ms;
      s1_code <= command_code;
      s1_amt  <= amount & AMT_MASK;
    end
  end

  // Timed outputs
  tdc_drive u_drive (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .apply   (s1_op),
    .code    (s1_code),
    .now     (s1_now),
    .amt     (s1_amt),
    .lvl     (lvl)
  );

  // Servo move decode
  always_comb begin
    pan_req.dec  = s1_op && (s1_code == CMD_PAN_RIGHT);
    pan_req.inc  = s1_op && (s1_code == CMD_PAN_LEFT);
    tilt_req.dec = s1_op && (s1_code == CMD_TILT_DOWN);
    tilt_req.inc = s1_op && (s1_code == CMD_TILT_UP);
  end

  tdc_servo_step u_pan_step (
    .req      (pan_req),
    .pos      (pan_pos),
    .amt      (s1_amt),
    .lo       (pan_min),
    .hi       (pan_max),
    .pos_next (pan_next)
  );

  tdc_servo_step u_tilt_step (
    .req      (tilt_req),
    .pos      (tilt_pos),
    .amt      (s1_amt),
    .lo       (tilt_min),
    .hi       (tilt_max),
    .pos_next (tilt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_pos  <= PAN_POS_RST;
      tilt_pos <= TILT_POS_RST;
    end else if (advance) begin
      pan_pos  <= pan_next;
      tilt_pos <= tilt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      right_fwd_on  <= lvl[SLOT_RF];
      right_back_on <= lvl[SLOT_RB];
      left_fwd_on   <= lvl[SLOT_LF];
      left_back_on  <= lvl[SLOT_LB];
      laser_on      <= lvl[SLOT_LASER];
      pan_period    <= pan_next;
      tilt_period   <= tilt_next;
    end
  end

  // Checks
  `ASSERT_NEXT(a_take_fills_s1, clk, rst, in_valid && !in_stall, s1_valid)
  `ASSERT_NEXT(a_advance_fills_out, clk, rst, s1_valid && !out_valid, out_valid)
  `ASSERT_IMPLY(a_full_pipe_stalls, clk, rst, s1_valid && out_valid && out_stall, in_stall)

endmodule

@@ rtl/core/tdc_servo_step.sv @@
// Saturating step of one servo pulse period: add or subtract an amount and clamp
// at the limit in the direction of motion. Depends on tdc_pkg.
module tdc_servo_step
  import tdc_pkg::*;
(
  input  tdc_step_req_t        req,
  input  logic [SERVO_W-1:0]   pos,
  input  logic [TIME_W-1:0]    amt,
  input  logic [SERVO_W-1:0]   lo,
  input  logic [SERVO_W-1:0]   hi,
  output logic [SERVO_W-1:0]   pos_next
);

  logic [TIME_W:0]      sum;
  logic [SERVO_W-1:0]   diff;
  logic                 under;

  // Wide sum and narrow difference; difference only used when amt <= pos
  assign sum   = {{(TIME_W+1-SERVO_W){1'b0}}, pos} + {1'b0, amt};
  assign under = amt > {{(TIME_W-SERVO_W){1'b0}}, pos};
  assign diff  = pos - amt[SERVO_W-1:0];

  // dec and inc never rise together; no request keeps the position
  always_comb begin
    pos_next = pos;
    if (req.dec) begin
      pos_next = (under || (diff < lo)) ? lo : diff;
    end else if (req.inc) begin
      pos_next = (sum > {{(TIME_W+1-SERVO_W){1'b0}}, hi}) ? hi : sum[SERVO_W-1:0];
    end
  end

endmodule

@@ rtl/core/tdc_drive.sv @@
// Expiry registers of the four wheel outputs and the laser, command update
// and the five expiry-versus-now compares. Depends on tdc_pkg.
module tdc_drive
  import tdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   apply,
  input  logic [CODE_W-1:0]      code,
  input  logic [TIME_W-1:0]      now,
  input  logic [TIME_W-1:0]      amt,
  output logic [SLOT_COUNT-1:0]  lvl
);

  logic [TIME_W-1:0] expiry      [SLOT_COUNT];
  logic [TIME_W-1:0] expiry_next [SLOT_COUNT];
  logic [TIME_W-1:0] fut;

  // Wraps modulo 2^32
  assign fut = now + amt;

  // Command update, then compare the updated expiries against now
  always_comb begin
    expiry_next = expiry;
    if (apply) begin
      unique case (tdc_cmd_t'(code))
        CMD_FWD: begin
          expiry_next[SLOT_RF] = fut;
          expiry_next[SLOT_RB] = now;
          expiry_next[SLOT_LF] = fut;
          expiry_next[SLOT_LB] = now;
        end
        CMD_BACK: begin
          expiry_next[SLOT_RF] = now;
          expiry_next[SLOT_RB] = fut;
          expiry_next[SLOT_LF] = now;
          expiry_next[SLOT_LB] = fut;
        end
        CMD_LEFT: begin
          expiry_next[SLOT_RF] = fut;
          expiry_next[SLOT_RB] = now;
          expiry_next[SLOT_LF] = now;
          expiry_next[SLOT_LB] = fut;
        end
        CMD_RIGHT: begin
          expiry_next[SLOT_RF] = now;
          expiry_next[SLOT_RB] = fut;
          expiry_next[SLOT_LF] = fut;
          expiry_next[SLOT_LB] = now;
        end
        CMD_FIRE: begin
          expiry_next[SLOT_LASER] = fut;
        end
        default: begin
          // servo moves and unknown codes leave the expiries alone
        end
      endcase
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      lvl[i] = expiry_next[i] > now;
    end
  end

  // Expiries commit when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= '{default: '0};
    end else if (advance) begin
      expiry <= expiry_next;
    end
  end

endmodule
